// File: hw/rtl/dcmf_pkg.sv
// ----------------------------------------------------------------------------
// dcmf_pkg
// Shared types, sizes and helpers of the dark channel minimum filter.
// ----------------------------------------------------------------------------
`default_nettype none

package dcmf_pkg;

   localparam int MAX_WIDTH  = 2048;
   localparam int MAX_HEIGHT = 2048;
   localparam int MAX_RADIUS = 25;

   localparam int NUM_HCELLS = 2 * MAX_RADIUS + 1;
   localparam int NUM_VCELLS = 2 * MAX_RADIUS;

   localparam int CFG_DIM_BITS = 12;
   localparam int CFG_RAD_BITS = 5;
   localparam int CSR_DATA_BITS = 12;
   localparam int CSR_INDEX_BITS = 2;

   localparam int EW_BITS   = $clog2(MAX_WIDTH + 1);
   localparam int EH_BITS   = $clog2(MAX_HEIGHT + 1);
   localparam int RAD_BITS  = $clog2(MAX_RADIUS + 1);
   localparam int COL_BITS  = $clog2(MAX_WIDTH);
   localparam int IROW_BITS = $clog2(MAX_HEIGHT);
   localparam int VROW_BITS = $clog2(MAX_HEIGHT + MAX_RADIUS + 1);
   localparam int HIDX_BITS = $clog2(NUM_HCELLS);
   localparam int VIDX_BITS = $clog2(NUM_VCELLS);

   localparam logic [7:0] PIX_MAX = 8'd255;

   localparam logic [CFG_DIM_BITS-1:0] RESET_WIDTH  = 12'd640;
   localparam logic [CFG_DIM_BITS-1:0] RESET_HEIGHT = 12'd480;
   localparam logic [CFG_RAD_BITS-1:0] RESET_RADIUS = 5'd5;

   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_FRAME_WIDTH  = 2'd0,
      REG_FRAME_HEIGHT = 2'd1,
      REG_FILTER_RADIUS = 2'd2,
      REG_UNUSED = 2'd3
   } reg_index_type;

   typedef logic [EW_BITS:0]   csum_type;
   typedef logic [VROW_BITS:0] rsum_type;
   typedef logic [HIDX_BITS-1:0] hidx_type;
   typedef logic [VIDX_BITS-1:0] vidx_type;

   typedef struct packed {
      logic       op;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } req_type;

   typedef struct packed {
      logic [7:0] dark_value;
      logic       frame_end;
   } rsp_type;

   // running window minimum and plain delayed sample
   typedef struct packed {
      logic [7:0] m;
      logic [7:0] d;
   } pair_type;

   function automatic logic [7:0] pix_min(input logic [7:0] a, input logic [7:0] b);
      pix_min = (a < b) ? a : b;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/dcmf_ram.sv
// ----------------------------------------------------------------------------
// dcmf_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module dcmf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2048
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: hw/rtl/dcmf_hcell.sv
// ----------------------------------------------------------------------------
// dcmf_hcell
// Horizontal cell: extends the neighbor's window minimum by the new sample.
// ----------------------------------------------------------------------------
`default_nettype none

module dcmf_hcell (
   input  wire logic               clock,
   input  wire logic               shift_en,
   input  wire logic [7:0]         sample,
   input  wire dcmf_pkg::pair_type prev_in,
   output dcmf_pkg::pair_type      cell_out
);

   dcmf_pkg::pair_type pair_ff;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         pair_ff.m <= dcmf_pkg::pix_min(prev_in.m, sample);
         pair_ff.d <= prev_in.d;
      end
   end

   assign cell_out = pair_ff;

endmodule

`default_nettype wire

// File: hw/rtl/dcmf_vcell.sv
// ----------------------------------------------------------------------------
// dcmf_vcell
// Vertical cell: one line of window minimum and delayed row values, kept per
// column, extended by the horizontal result of the current row.
// ----------------------------------------------------------------------------
`default_nettype none

module dcmf_vcell (
   input  wire logic                          clock,
   input  wire logic                          rd_en,
   input  wire logic [dcmf_pkg::COL_BITS-1:0] rd_addr,
   input  wire logic                          wr_en,
   input  wire logic [dcmf_pkg::COL_BITS-1:0] wr_addr,
   input  wire logic [7:0]                    h_value,
   input  wire dcmf_pkg::pair_type            prev_in,
   output dcmf_pkg::pair_type                 cell_out
);

   dcmf_pkg::pair_type wr_pair;
   logic [$bits(dcmf_pkg::pair_type)-1:0] rd_bits;

   assign wr_pair.m = dcmf_pkg::pix_min(prev_in.m, h_value);
   assign wr_pair.d = prev_in.d;

   dcmf_ram #(
      .WIDTH($bits(dcmf_pkg::pair_type)),
      .DEPTH(dcmf_pkg::MAX_WIDTH)
   ) u_line (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_pair),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_bits)
   );

   assign cell_out = dcmf_pkg::pair_type'(rd_bits);

endmodule

`default_nettype wire

// File: hw/rtl/dark_channel_min_filter.sv
// ----------------------------------------------------------------------------
// dark_channel_min_filter
// Dark channel of a raster pixel stream: channel minimum, then a separable
// square minimum filter with edge pass-through.
// ----------------------------------------------------------------------------
// The accept cycle shifts the horizontal cell row and reads every vertical
// line RAM at the current column. The next cycle forms the result and writes
// the line RAMs back. A new item is taken after that. Results trail their
// pixel by radius rows plus radius pixels. Once the frame is fully in, each
// further item (pixel or drain) releases one result. When radius rows plus
// radius pixels exceeds the frame size, no result is ready for the first beat
// after the frame is in. That beat holds the input while the filter steps on
// its own, with no new input. The first such beat needs radius * width +
// radius - width * height extra steps. Each later beat needs no extra step.
// There is no clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module dark_channel_min_filter (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire dcmf_pkg::req_type                   req_payload,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output dcmf_pkg::rsp_type                        rsp_payload,
   input  wire logic                                csr_we,
   input  wire logic [dcmf_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [dcmf_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_CALC = 3'b010,
      ST_STEP = 3'b100
   } state_type;

   state_type state_ff, state_in;

   logic [dcmf_pkg::CFG_DIM_BITS-1:0] cfg_width_ff, cfg_height_ff;
   logic [dcmf_pkg::CFG_RAD_BITS-1:0] cfg_radius_ff;

   logic [dcmf_pkg::EW_BITS-1:0]  eff_w;
   logic [dcmf_pkg::EH_BITS-1:0]  eff_h;
   logic [dcmf_pkg::RAD_BITS-1:0] eff_r;

   logic [dcmf_pkg::RAD_BITS-1:0]  tcnt_ff, tcnt_in;
   logic [dcmf_pkg::IROW_BITS-1:0] in_row_ff, in_row_in;
   logic [dcmf_pkg::COL_BITS-1:0]  in_col_ff, in_col_in;
   logic                           in_done_ff, in_done_in;
   logic [dcmf_pkg::VROW_BITS-1:0] vrow_ff, vrow_in;
   logic [dcmf_pkg::COL_BITS-1:0]  vcol_ff, vcol_in;
   logic [dcmf_pkg::IROW_BITS-1:0] orow_ff, orow_in;
   logic [dcmf_pkg::COL_BITS-1:0]  ocol_ff, ocol_in;
   logic [dcmf_pkg::COL_BITS-1:0]  jcol_ff, jcol_in;
   logic                           hv_ff, hv_in;
   logic                           em_ff, em_in;
   logic                           owe_ff, owe_in;

   logic              rsp_valid_ff, rsp_valid_in;
   dcmf_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic       req_fire, advance;
   logic [7:0] gray, sample;
   logic [7:0] h_value, dsel, msel;
   logic       col_inner, row_edge, last_pix, last_out, cfg_hit;

   dcmf_pkg::pair_type hout [dcmf_pkg::NUM_HCELLS];
   dcmf_pkg::pair_type vrd  [dcmf_pkg::NUM_VCELLS];

   // effective frame geometry
   always_comb begin
      if (cfg_width_ff == '0) begin
         eff_w = dcmf_pkg::EW_BITS'(1);
      end else if (32'(cfg_width_ff) > dcmf_pkg::MAX_WIDTH) begin
         eff_w = dcmf_pkg::EW_BITS'(dcmf_pkg::MAX_WIDTH);
      end else begin
         eff_w = dcmf_pkg::EW_BITS'(cfg_width_ff);
      end
      if (cfg_height_ff == '0) begin
         eff_h = dcmf_pkg::EH_BITS'(1);
      end else if (32'(cfg_height_ff) > dcmf_pkg::MAX_HEIGHT) begin
         eff_h = dcmf_pkg::EH_BITS'(dcmf_pkg::MAX_HEIGHT);
      end else begin
         eff_h = dcmf_pkg::EH_BITS'(cfg_height_ff);
      end
      if (32'(cfg_radius_ff) > dcmf_pkg::MAX_RADIUS) begin
         eff_r = dcmf_pkg::RAD_BITS'(dcmf_pkg::MAX_RADIUS);
      end else begin
         eff_r = dcmf_pkg::RAD_BITS'(cfg_radius_ff);
      end
   end

   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_fire  = req_valid && req_ready;
   assign advance   = (req_fire && (in_done_ff || (req_payload.op == dcmf_pkg::OP_PIXEL))) ||
                      (state_ff == ST_STEP);

   assign gray = dcmf_pkg::pix_min(dcmf_pkg::pix_min(req_payload.red, req_payload.green),
                                   req_payload.blue);
   assign sample = in_done_ff ? dcmf_pkg::PIX_MAX : gray;

   // horizontal cell row
   for (genvar k = 0; k < dcmf_pkg::NUM_HCELLS; k++) begin : g_hcell
      dcmf_pkg::pair_type prev;
      if (k == 0) begin : g_head
         assign prev = '{m: dcmf_pkg::PIX_MAX, d: sample};
      end else begin : g_link
         assign prev = hout[k-1];
      end
      dcmf_hcell u_hcell (
         .clock   (clock),
         .shift_en(advance),
         .sample  (sample),
         .prev_in (prev),
         .cell_out(hout[k])
      );
   end

   // horizontal result of the column entering the vertical row
   assign col_inner = (dcmf_pkg::csum_type'(jcol_ff) >= dcmf_pkg::csum_type'(eff_r)) &&
                      (dcmf_pkg::csum_type'(jcol_ff) + dcmf_pkg::csum_type'(eff_r) <
                       dcmf_pkg::csum_type'(eff_w));
   assign h_value = col_inner ? hout[dcmf_pkg::hidx_type'({eff_r, 1'b0})].m
                              : hout[dcmf_pkg::hidx_type'(eff_r)].d;

   // vertical cell row, one line RAM per cell
   for (genvar k = 0; k < dcmf_pkg::NUM_VCELLS; k++) begin : g_vcell
      dcmf_pkg::pair_type prev;
      if (k == 0) begin : g_head
         assign prev = '{m: dcmf_pkg::PIX_MAX, d: h_value};
      end else begin : g_link
         assign prev = vrd[k-1];
      end
      dcmf_vcell u_vcell (
         .clock   (clock),
         .rd_en   (advance),
         .rd_addr (vcol_ff),
         .wr_en   ((state_ff == ST_CALC) && hv_ff),
         .wr_addr (jcol_ff),
         .h_value (h_value),
         .prev_in (prev),
         .cell_out(vrd[k])
      );
   end

   assign row_edge = (dcmf_pkg::rsum_type'(orow_ff) < dcmf_pkg::rsum_type'(eff_r)) ||
                     (dcmf_pkg::rsum_type'(orow_ff) + dcmf_pkg::rsum_type'(eff_r) >=
                      dcmf_pkg::rsum_type'(eff_h));

   always_comb begin
      if (eff_r == '0) begin
         dsel = h_value;
         msel = h_value;
      end else begin
         dsel = vrd[dcmf_pkg::vidx_type'(eff_r - 1'b1)].d;
         msel = dcmf_pkg::pix_min(vrd[dcmf_pkg::vidx_type'({eff_r, 1'b0} - 1'b1)].m,
                                  h_value);
      end
   end

   assign last_pix = (dcmf_pkg::csum_type'(in_col_ff) + 1'b1 == dcmf_pkg::csum_type'(eff_w)) &&
                     (dcmf_pkg::rsum_type'(in_row_ff) + 1'b1 == dcmf_pkg::rsum_type'(eff_h));
   assign last_out = (dcmf_pkg::csum_type'(ocol_ff) + 1'b1 == dcmf_pkg::csum_type'(eff_w)) &&
                     (dcmf_pkg::rsum_type'(orow_ff) + 1'b1 == dcmf_pkg::rsum_type'(eff_h));
   assign cfg_hit  = csr_we && (csr_index != dcmf_pkg::REG_UNUSED);

   always_comb begin
      state_in     = state_ff;
      tcnt_in      = tcnt_ff;
      in_row_in    = in_row_ff;
      in_col_in    = in_col_ff;
      in_done_in   = in_done_ff;
      vrow_in      = vrow_ff;
      vcol_in      = vcol_ff;
      orow_in      = orow_ff;
      ocol_in      = ocol_ff;
      jcol_in      = jcol_ff;
      hv_in        = hv_ff;
      em_in        = em_ff;
      owe_in       = owe_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff) inside
         ST_IDLE, ST_STEP: begin
            if (advance) begin
               // a beat taken after the frame is in owes one result
               if (req_fire && in_done_ff) begin
                  owe_in = 1'b1;
               end
               if (!in_done_ff) begin
                  if (last_pix) begin
                     in_done_in = 1'b1;
                  end
                  if (dcmf_pkg::csum_type'(in_col_ff) + 1'b1 ==
                      dcmf_pkg::csum_type'(eff_w)) begin
                     in_col_in = '0;
                     in_row_in = in_row_ff + 1'b1;
                  end else begin
                     in_col_in = in_col_ff + 1'b1;
                  end
               end
               hv_in   = (tcnt_ff >= eff_r);
               em_in   = (tcnt_ff >= eff_r) &&
                         (dcmf_pkg::rsum_type'(vrow_ff) >= dcmf_pkg::rsum_type'(eff_r));
               jcol_in = vcol_ff;
               if (tcnt_ff < eff_r) begin
                  tcnt_in = tcnt_ff + 1'b1;
               end else begin
                  // advance the vertical entry position
                  if (dcmf_pkg::csum_type'(vcol_ff) + 1'b1 == dcmf_pkg::csum_type'(eff_w)) begin
                     vcol_in = '0;
                     vrow_in = vrow_ff + 1'b1;
                  end else begin
                     vcol_in = vcol_ff + 1'b1;
                  end
               end
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            state_in = ST_IDLE;
            if (em_ff) begin
               owe_in                 = 1'b0;
               rsp_valid_in           = 1'b1;
               rsp_data_in.dark_value = row_edge ? dsel : msel;
               rsp_data_in.frame_end  = last_out;
               if (last_out) begin
                  // frame done: restart every position
                  tcnt_in    = '0;
                  in_row_in  = '0;
                  in_col_in  = '0;
                  in_done_in = 1'b0;
                  vrow_in    = '0;
                  vcol_in    = '0;
                  orow_in    = '0;
                  ocol_in    = '0;
               end else if (dcmf_pkg::csum_type'(ocol_ff) + 1'b1 ==
                            dcmf_pkg::csum_type'(eff_w)) begin
                  ocol_in = '0;
                  orow_in = orow_ff + 1'b1;
               end else begin
                  ocol_in = ocol_ff + 1'b1;
               end
            end else if (owe_ff) begin
               // hold the input and step the filter until the owed result is out
               state_in = ST_STEP;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // a write to a used register restarts the frame
      if (cfg_hit) begin
         tcnt_in    = '0;
         in_row_in  = '0;
         in_col_in  = '0;
         in_done_in = 1'b0;
         vrow_in    = '0;
         vcol_in    = '0;
         orow_in    = '0;
         ocol_in    = '0;
         owe_in     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cfg_width_ff  <= dcmf_pkg::RESET_WIDTH;
         cfg_height_ff <= dcmf_pkg::RESET_HEIGHT;
         cfg_radius_ff <= dcmf_pkg::RESET_RADIUS;
         tcnt_ff       <= '0;
         in_row_ff     <= '0;
         in_col_ff     <= '0;
         in_done_ff    <= 1'b0;
         vrow_ff       <= '0;
         vcol_ff       <= '0;
         orow_ff       <= '0;
         ocol_ff       <= '0;
         hv_ff         <= 1'b0;
         em_ff         <= 1'b0;
         owe_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tcnt_ff      <= tcnt_in;
         in_row_ff    <= in_row_in;
         in_col_ff    <= in_col_in;
         in_done_ff   <= in_done_in;
         vrow_ff      <= vrow_in;
         vcol_ff      <= vcol_in;
         orow_ff      <= orow_in;
         ocol_ff      <= ocol_in;
         hv_ff        <= hv_in;
         em_ff        <= em_in;
         owe_ff       <= owe_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               dcmf_pkg::REG_FRAME_WIDTH:   cfg_width_ff  <= csr_wdata;
               dcmf_pkg::REG_FRAME_HEIGHT:  cfg_height_ff <= csr_wdata;
               dcmf_pkg::REG_FILTER_RADIUS: cfg_radius_ff <= csr_wdata[dcmf_pkg::CFG_RAD_BITS-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      jcol_ff     <= jcol_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

endmodule

`default_nettype wire
